[hw/rtl/cde_pkg.sv]
package cde_pkg;

    // Store geometry
    localparam int STORE_DEPTH = 16;
    localparam int POS_W       = $clog2(STORE_DEPTH);
    localparam int CNT_W       = $clog2(STORE_DEPTH + 1);

    // Field widths
    localparam int CAP_W    = 5;
    localparam int REQ_W    = 3;
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 2;

    typedef enum logic [REQ_W-1:0] {
        REQ_PUSH_FRONT = 3'd0,
        REQ_PUSH_REAR  = 3'd1,
        REQ_POP_FRONT  = 3'd2,
        REQ_POP_REAR   = 3'd3,
        REQ_PEEK_FRONT = 3'd4,
        REQ_PEEK_REAR  = 3'd5,
        REQ_DUMP       = 3'd6,
        REQ_NONE       = 3'd7
    } req_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK           = 2'd0,
        ST_FULL         = 2'd1,
        ST_EMPTY        = 2'd2,
        ST_FRONT_REFUSE = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_PEEK,
        S_DUMP
    } state_t;

endpackage

[hw/rtl/circular_deque_engine_unit.sv]
// Double-ended queue held in a 16-entry synchronous memory. Each request word on the
// slave side (tuser = request code, tdata = element) pushes or pops at either end,
// peeks at either end, or dumps the queue front to rear. A push or pop puts its
// result word in the output register on the next cycle. A peek passes the word
// through the memory read register first. A dump reads from the front and sends one
// entry per word whenever the output register is free; tlast marks the final word.
// All timing follows from the single read port of the element memory. A new request
// is taken once the previous one is finished and the output register is empty or
// being drained in the same cycle. Writing capacity_in_use (1..16; 0 acts as 1,
// above 16 as 16) empties the queue. Write it only while no request is in flight.
module circular_deque_engine_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    // configuration: capacity_in_use
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [cde_pkg::CAP_W-1:0]      cfg_data,
    // request stream
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [cde_pkg::DATA_W-1:0]     s_tdata,   // [31:0] data_value
    input  logic [cde_pkg::REQ_W-1:0]      s_tuser,   // [2:0] req_type
    // result stream
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [cde_pkg::DATA_W-1:0]     m_tdata,   // [31:0] data_out
    output logic [3:0]                     m_tuser,   // [1:0] status, [2] is_full,
                                                      // [3] is_empty
    output logic                           m_tlast    // last_of_run
);

    localparam int POS_W = cde_pkg::POS_W;
    localparam int CNT_W = cde_pkg::CNT_W;

    // Element memory
    logic [cde_pkg::DATA_W-1:0] mem [cde_pkg::STORE_DEPTH];
    logic [cde_pkg::DATA_W-1:0] mem_rdata_reg;
    logic [POS_W-1:0]           rd_addr;
    logic [POS_W-1:0]           wr_addr;
    logic                       mem_we;

    // Control state
    cde_pkg::state_t            state_reg, state_next;
    logic [cde_pkg::CAP_W-1:0]  cap_reg, cap_next;
    logic [POS_W-1:0]           front_reg, front_next;
    logic [POS_W-1:0]           rear_reg, rear_next;
    logic [CNT_W-1:0]           occ_reg, occ_next;
    logic [POS_W-1:0]           dptr_reg, dptr_next;
    logic [CNT_W-1:0]           dcnt_reg, dcnt_next;

    // Output register
    logic                       m_tvalid_reg, m_tvalid_next;
    logic [cde_pkg::DATA_W-1:0] m_tdata_reg, m_tdata_next;
    cde_pkg::status_t           status_reg, status_next;
    logic                       last_reg, last_next;
    logic                       full_reg, full_next;
    logic                       empty_reg, empty_next;

    logic [CNT_W-1:0]           eff_cap;
    logic                       out_free;
    logic                       accept;
    cde_pkg::req_t              req;

    function automatic logic [POS_W-1:0] wrap_inc(input logic [POS_W-1:0] p,
                                                  input logic [CNT_W-1:0] cap);
        logic [CNT_W-1:0] p1;
        p1 = CNT_W'(p) + CNT_W'(1);
        return (p1 >= cap) ? '0 : POS_W'(p1);
    endfunction

    function automatic logic [POS_W-1:0] wrap_dec(input logic [POS_W-1:0] p,
                                                  input logic [CNT_W-1:0] cap);
        logic [CNT_W-1:0] cm1;
        cm1 = cap - CNT_W'(1);
        return (p == '0 || CNT_W'(p) >= cap) ? POS_W'(cm1) : p - POS_W'(1);
    endfunction

    // Clamp capacity into 1..STORE_DEPTH
    always_comb
    begin
        if (cap_reg == '0)
        begin
            eff_cap = CNT_W'(1);
        end
        else if (32'(cap_reg) > cde_pkg::STORE_DEPTH)
        begin
            eff_cap = CNT_W'(cde_pkg::STORE_DEPTH);
        end
        else
        begin
            eff_cap = CNT_W'(cap_reg);
        end
    end

    assign out_free  = !m_tvalid_reg || m_tready;
    assign s_tready  = (state_reg == cde_pkg::S_IDLE) && out_free;
    assign accept    = s_tvalid && s_tready;
    assign req       = cde_pkg::req_t'(s_tuser);
    assign cfg_ready = 1'b1;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = {empty_reg, full_reg, status_reg};
    assign m_tlast  = last_reg;

    // Next state, memory access and result formation
    always_comb
    begin
        state_next    = state_reg;
        cap_next      = cap_reg;
        front_next    = front_reg;
        rear_next     = rear_reg;
        occ_next      = occ_reg;
        dptr_next     = dptr_reg;
        dcnt_next     = dcnt_reg;
        rd_addr       = front_reg;
        wr_addr       = rear_reg;
        mem_we        = 1'b0;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        status_next   = status_reg;
        last_next     = last_reg;
        full_next     = full_reg;
        empty_next    = empty_reg;

        case (state_reg)
            cde_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    status_next  = cde_pkg::ST_OK;
                    m_tdata_next = '0;
                    last_next    = 1'b1;
                    case (req)
                        cde_pkg::REQ_PUSH_FRONT:
                        begin
                            if (occ_reg >= eff_cap)
                            begin
                                status_next = cde_pkg::ST_FULL;
                            end
                            else if (occ_reg == '0)
                            begin
                                status_next = cde_pkg::ST_FRONT_REFUSE;
                            end
                            else
                            begin
                                front_next = wrap_dec(front_reg, eff_cap);
                                wr_addr    = front_next;
                                mem_we     = 1'b1;
                                occ_next   = occ_reg + CNT_W'(1);
                            end
                        end
                        cde_pkg::REQ_PUSH_REAR:
                        begin
                            if (occ_reg >= eff_cap)
                            begin
                                status_next = cde_pkg::ST_FULL;
                            end
                            else
                            begin
                                if (occ_reg == '0)
                                begin
                                    front_next = '0;
                                    rear_next  = '0;
                                end
                                else
                                begin
                                    rear_next = wrap_inc(rear_reg, eff_cap);
                                end
                                wr_addr  = rear_next;
                                mem_we   = 1'b1;
                                occ_next = occ_reg + CNT_W'(1);
                            end
                        end
                        cde_pkg::REQ_POP_FRONT,
                        cde_pkg::REQ_POP_REAR:
                        begin
                            if (occ_reg == '0)
                            begin
                                status_next = cde_pkg::ST_EMPTY;
                            end
                            else if (occ_reg == CNT_W'(1))
                            begin
                                occ_next   = '0;
                                front_next = '0;
                                rear_next  = '0;
                            end
                            else
                            begin
                                if (req == cde_pkg::REQ_POP_FRONT)
                                begin
                                    front_next = wrap_inc(front_reg, eff_cap);
                                end
                                else
                                begin
                                    rear_next = wrap_dec(rear_reg, eff_cap);
                                end
                                occ_next = occ_reg - CNT_W'(1);
                            end
                        end
                        cde_pkg::REQ_PEEK_FRONT,
                        cde_pkg::REQ_PEEK_REAR:
                        begin
                            if (occ_reg == '0)
                            begin
                                status_next = cde_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                // read now, present the word from the read register in S_PEEK
                                rd_addr    = (req == cde_pkg::REQ_PEEK_FRONT) ?
                                             front_reg : rear_reg;
                                state_next = cde_pkg::S_PEEK;
                            end
                        end
                        cde_pkg::REQ_DUMP:
                        begin
                            if (occ_reg == '0)
                            begin
                                status_next = cde_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                rd_addr    = front_reg;
                                dptr_next  = front_reg;
                                dcnt_next  = '0;
                                state_next = cde_pkg::S_DUMP;
                            end
                        end
                        default:
                        begin
                            // unused code: plain ok word
                        end
                    endcase
                    // Emit at once unless the word waits on a memory read
                    if (state_next == cde_pkg::S_IDLE)
                    begin
                        m_tvalid_next = 1'b1;
                        full_next     = (occ_next == eff_cap);
                        empty_next    = (occ_next == '0);
                    end
                end
            end
            cde_pkg::S_PEEK:
            begin
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = mem_rdata_reg;
                    status_next   = cde_pkg::ST_OK;
                    last_next     = 1'b1;
                    full_next     = (occ_reg == eff_cap);
                    empty_next    = (occ_reg == '0);
                    state_next    = cde_pkg::S_IDLE;
                end
            end
            cde_pkg::S_DUMP:
            begin
                // hold the read address until the current word can leave
                rd_addr = dptr_reg;
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = mem_rdata_reg;
                    status_next   = cde_pkg::ST_OK;
                    last_next     = (dcnt_reg + CNT_W'(1) == occ_reg);
                    full_next     = (occ_reg == eff_cap);
                    empty_next    = (occ_reg == '0);
                    if (last_next)
                    begin
                        state_next = cde_pkg::S_IDLE;
                    end
                    else
                    begin
                        dptr_next = wrap_inc(dptr_reg, eff_cap);
                        dcnt_next = dcnt_reg + CNT_W'(1);
                        rd_addr   = dptr_next;
                    end
                end
            end
            default:
            begin
                state_next = cde_pkg::S_IDLE;
            end
        endcase

        // A capacity write empties the queue
        if (cfg_valid && cfg_ready)
        begin
            cap_next   = cfg_data;
            occ_next   = '0;
            front_next = '0;
            rear_next  = '0;
        end
    end

    // Memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wr_addr] <= s_tdata;
        end
        mem_rdata_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= cde_pkg::S_IDLE;
            cap_reg      <= cde_pkg::CAP_W'(16);
            front_reg    <= '0;
            rear_reg     <= '0;
            occ_reg      <= '0;
            dptr_reg     <= '0;
            dcnt_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cap_reg      <= cap_next;
            front_reg    <= front_next;
            rear_reg     <= rear_next;
            occ_reg      <= occ_next;
            dptr_reg     <= dptr_next;
            dcnt_reg     <= dcnt_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        m_tdata_reg <= m_tdata_next;
        status_reg  <= status_next;
        last_reg    <= last_next;
        full_reg    <= full_next;
        empty_reg   <= empty_next;
    end

endmodule

[tb/testbench.sv]
`timescale 1ns / 100ps

module testbench;

    localparam int          CLK_PERIOD  = 20;
    localparam int          RESET_TICKS = 11;
    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned LONG_HOLD   = 300;
    localparam int unsigned REPORT_MAX  = 10;
    localparam int unsigned SETTLE_GAP  = 4;

    // One result word as the block should present it
    typedef struct {
        cde_pkg::status_t             status;
        logic [cde_pkg::DATA_W-1:0]   data;
        logic                         last;
        logic                         full;
        logic                         empty;
    } deque_word_t;

    // Mirror of the deque: slots, end positions, occupancy and capacity register,
    // plus the queue of result words still owed by the block.
    class deque_scoreboard;
        logic [cde_pkg::DATA_W-1:0] slots [cde_pkg::STORE_DEPTH];
        bit [cde_pkg::POS_W-1:0]    front_pos  = '0;
        bit [cde_pkg::POS_W-1:0]    rear_pos   = '0;
        bit [cde_pkg::CNT_W-1:0]    count      = '0;
        bit [cde_pkg::CAP_W-1:0]    cap_reg    = cde_pkg::CAP_W'(cde_pkg::STORE_DEPTH);
        deque_word_t                owed_words [$];
        int unsigned                fail_count = 0;

        function int unsigned active_capacity();
            if (cap_reg == 0)
                return 1;
            if (cap_reg > cde_pkg::STORE_DEPTH)
                return cde_pkg::STORE_DEPTH;
            return cap_reg;
        endfunction

        function bit [cde_pkg::POS_W-1:0] step_up(bit [cde_pkg::POS_W-1:0] p);
            int unsigned q;
            q = p;
            return (q + 1 >= active_capacity()) ? '0 : cde_pkg::POS_W'(q + 1);
        endfunction

        function bit [cde_pkg::POS_W-1:0] step_down(bit [cde_pkg::POS_W-1:0] p);
            int unsigned q;
            q = p;
            return (q == 0 || q >= active_capacity())
                   ? cde_pkg::POS_W'(active_capacity() - 1)
                   : cde_pkg::POS_W'(q - 1);
        endfunction

        function void clear_positions();
            count     = '0;
            front_pos = '0;
            rear_pos  = '0;
        endfunction

        function void set_capacity(bit [cde_pkg::CAP_W-1:0] value);
            cap_reg = value;
            clear_positions();
        endfunction

        function void owe_word(cde_pkg::status_t st, logic [cde_pkg::DATA_W-1:0] value,
                               logic last);
            deque_word_t w;
            w.status = st;
            w.data   = value;
            w.last   = last;
            w.full   = (count == active_capacity());
            w.empty  = (count == 0);
            owed_words.push_back(w);
        endfunction

        function int unsigned pending();
            return owed_words.size();
        endfunction

        // Apply one accepted request and queue the words it causes
        function void note_request(cde_pkg::req_t req, logic [cde_pkg::DATA_W-1:0] value);
            int unsigned                n;
            bit [cde_pkg::POS_W-1:0]    p;
            cde_pkg::status_t           st;
            logic [cde_pkg::DATA_W-1:0] rd;
            st = cde_pkg::ST_OK;
            rd = '0;
            case (req)
                cde_pkg::REQ_PUSH_FRONT:
                    if (count >= active_capacity())
                        st = cde_pkg::ST_FULL;
                    else if (count == 0)
                        st = cde_pkg::ST_FRONT_REFUSE;
                    else
                    begin
                        front_pos        = step_down(front_pos);
                        slots[front_pos] = value;
                        count++;
                    end
                cde_pkg::REQ_PUSH_REAR:
                    if (count >= active_capacity())
                        st = cde_pkg::ST_FULL;
                    else
                    begin
                        if (count == 0)
                        begin
                            front_pos = '0;
                            rear_pos  = '0;
                        end
                        else
                            rear_pos = step_up(rear_pos);
                        slots[rear_pos] = value;
                        count++;
                    end
                cde_pkg::REQ_POP_FRONT, cde_pkg::REQ_POP_REAR:
                    if (count == 0)
                        st = cde_pkg::ST_EMPTY;
                    else if (count == 1)
                        clear_positions();
                    else
                    begin
                        if (req == cde_pkg::REQ_POP_FRONT)
                            front_pos = step_up(front_pos);
                        else
                            rear_pos = step_down(rear_pos);
                        count--;
                    end
                cde_pkg::REQ_PEEK_FRONT, cde_pkg::REQ_PEEK_REAR:
                    if (count == 0)
                        st = cde_pkg::ST_EMPTY;
                    else
                        rd = slots[(req == cde_pkg::REQ_PEEK_FRONT) ? front_pos : rear_pos];
                cde_pkg::REQ_DUMP:
                    if (count == 0)
                        st = cde_pkg::ST_EMPTY;
                    else
                    begin
                        n = count;
                        p = front_pos;
                        for (int k = 0; k < n; k++)
                        begin
                            owe_word(cde_pkg::ST_OK, slots[p], (k + 1 == n));
                            p = step_up(p);
                        end
                        return;
                    end
                default:
                    ;
            endcase
            owe_word(st, rd, 1'b1);
        endfunction

        // Compare one accepted result word with the oldest owed word
        function void check_result(logic [cde_pkg::DATA_W-1:0] data, logic [3:0] user,
                                   logic last);
            deque_word_t w;
            if (owed_words.size() == 0)
            begin
                if (fail_count < REPORT_MAX)
                    $display("unexpected word: data=%h user=%b last=%b", data, user, last);
                fail_count++;
                return;
            end
            w = owed_words.pop_front();
            if (user[1:0] !== w.status || data !== w.data || last !== w.last
                || user[2] !== w.full || user[3] !== w.empty)
            begin
                if (fail_count < REPORT_MAX)
                begin
                    $display("word mismatch: exp st=%0d d=%h last=%b full=%b empty=%b",
                             w.status, w.data, w.last, w.full, w.empty);
                    $display("               act st=%0d d=%h last=%b full=%b empty=%b",
                             user[1:0], data, last, user[2], user[3]);
                end
                fail_count++;
            end
        endfunction
    endclass

    logic                        clk       = 1'b0;
    logic                        rst_n     = 1'b0;
    logic                        cfg_valid = 1'b0;
    logic                        cfg_ready;
    logic [cde_pkg::CAP_W-1:0]   cfg_data  = '0;
    logic                        s_tvalid  = 1'b0;
    logic                        s_tready;
    logic [cde_pkg::DATA_W-1:0]  s_tdata   = '0;
    logic [cde_pkg::REQ_W-1:0]   s_tuser   = '0;
    logic                        m_tvalid;
    logic                        m_tready  = 1'b0;
    logic [cde_pkg::DATA_W-1:0]  m_tdata;
    logic [3:0]                  m_tuser;
    logic                        m_tlast;

    deque_scoreboard    sb = new;
    bit                 long_hold_req = 1'b0;

    circular_deque_engine_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    initial
    begin
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // Offer one request word and hold it until the block takes it
    task automatic send_request(input cde_pkg::req_t req,
                                input logic [cde_pkg::DATA_W-1:0] value);
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= value;
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_request(req, value);
    endtask

    // Drop valid for a number of cycles (n >= 1)
    task automatic idle_cycles(input int unsigned n);
        s_tvalid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    // Hold off until every owed word has come back, then let the pipeline settle
    task automatic wait_drained();
        idle_cycles(1);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_GAP) @(posedge clk);
    endtask

    // Write capacity_in_use; only called with the block idle
    task automatic write_capacity(input logic [cde_pkg::CAP_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.set_capacity(value);
    endtask

    function automatic logic [cde_pkg::DATA_W-1:0] pick_value();
        case ($urandom_range(0, 7))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            default: return $urandom();
        endcase
    endfunction

    // Weight pushes by push_pct so the deque reaches full and wraps around
    function automatic cde_pkg::req_t pick_request(input int unsigned push_pct);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < push_pct)
            return $urandom_range(0, 1) ? cde_pkg::REQ_PUSH_REAR : cde_pkg::REQ_PUSH_FRONT;
        r = $urandom_range(0, 99);
        if (r < 40)
            return $urandom_range(0, 1) ? cde_pkg::REQ_POP_REAR : cde_pkg::REQ_POP_FRONT;
        if (r < 75)
            return $urandom_range(0, 1) ? cde_pkg::REQ_PEEK_REAR : cde_pkg::REQ_PEEK_FRONT;
        if (r < 96)
            return cde_pkg::REQ_DUMP;
        return cde_pkg::REQ_NONE;
    endfunction

    // One setting of capacity: write it, then stream random requests in bursts.
    // With back_to_back set, the sender never idles and the sink is told to stall.
    task automatic run_phase(input logic [cde_pkg::CAP_W-1:0] capacity,
                             input int unsigned n_items,
                             input int unsigned push_pct, input bit back_to_back);
        int unsigned burst_left;
        wait_drained();
        write_capacity(capacity);
        burst_left = $urandom_range(1, 12);
        if (back_to_back)
            long_hold_req = 1'b1;
        for (int i = 0; i < n_items; i++)
        begin
            // pause mid-phase until all owed words are back
            if (i == n_items / 2 && !back_to_back)
                wait_drained();
            send_request(pick_request(push_pct), pick_value());
            if (!back_to_back)
            begin
                burst_left--;
                if (burst_left == 0)
                begin
                    idle_cycles($urandom_range(1, 6));
                    burst_left = $urandom_range(1, 12);
                end
            end
        end
    endtask

    // Result sink: check every accepted word, stall on a pattern that switches
    // between always-ready, coin-flip, sparse and mostly-ready stretches.
    initial
    begin : result_sink
        int unsigned mode;
        int unsigned mode_left;
        int unsigned hold_left;
        mode      = 0;
        mode_left = 0;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
                sb.check_result(m_tdata, m_tuser, m_tlast);
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                hold_left     = LONG_HOLD;
            end
            if (mode_left == 0)
            begin
                mode      = $urandom_range(0, 3);
                mode_left = $urandom_range(8, 80);
            end
            else
                mode_left--;
            if (hold_left != 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
                case (mode)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= $urandom_range(0, 1);
                    2:       m_tready <= ($urandom_range(0, 3) == 0);
                    default: m_tready <= ($urandom_range(0, 7) != 0);
                endcase
        end
    end

    // Watchdog: end the run if it hangs
    initial
    begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("circular_deque_engine_unit regression: fail");
        $finish;
    end

    initial
    begin : stimulus
        repeat (RESET_TICKS) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed, capacity at its reset value: empty cases first
        send_request(cde_pkg::REQ_PEEK_FRONT, 32'h0);
        send_request(cde_pkg::REQ_PEEK_REAR,  32'h0);
        send_request(cde_pkg::REQ_POP_FRONT,  32'h0);
        send_request(cde_pkg::REQ_POP_REAR,   32'h0);
        send_request(cde_pkg::REQ_DUMP,       32'h0);
        send_request(cde_pkg::REQ_PUSH_FRONT, 32'h1234_5678);   // refused on empty
        send_request(cde_pkg::REQ_NONE,       32'hFFFF_FFFF);   // code without a meaning
        send_request(cde_pkg::REQ_PUSH_REAR,  32'h7FFF_FFFF);   // first rear push at slot 0
        send_request(cde_pkg::REQ_PUSH_REAR,  32'h8000_0000);
        send_request(cde_pkg::REQ_PUSH_FRONT, 32'hFFFF_FFFF);   // front wraps below slot 0
        send_request(cde_pkg::REQ_PUSH_FRONT, 32'h0000_0000);
        send_request(cde_pkg::REQ_PEEK_FRONT, 32'h0);
        send_request(cde_pkg::REQ_PEEK_REAR,  32'h0);
        send_request(cde_pkg::REQ_DUMP,       32'h0);
        send_request(cde_pkg::REQ_POP_FRONT,  32'h0);
        send_request(cde_pkg::REQ_POP_REAR,   32'h0);
        send_request(cde_pkg::REQ_POP_FRONT,  32'h0);
        send_request(cde_pkg::REQ_POP_REAR,   32'h0);           // last entry: positions reset

        // Directed, smallest capacity: pushes at either end on a full deque
        wait_drained();
        write_capacity(cde_pkg::CAP_W'(1));
        send_request(cde_pkg::REQ_PUSH_REAR,  32'hA5A5_5A5A);
        send_request(cde_pkg::REQ_PUSH_REAR,  32'h0F0F_F0F0);   // full
        send_request(cde_pkg::REQ_PUSH_FRONT, 32'h5555_AAAA);   // full, not refused
        send_request(cde_pkg::REQ_DUMP,       32'h0);
        send_request(cde_pkg::REQ_POP_FRONT,  32'h0);

        // Random phases over several capacities, extremes included
        run_phase(cde_pkg::CAP_W'(16), 30, 70, 1'b0);
        run_phase(cde_pkg::CAP_W'(16), 40, 70, 1'b1);           // sink stalls, input backs up
        run_phase(cde_pkg::CAP_W'(1),  15, 50, 1'b0);
        run_phase(cde_pkg::CAP_W'(0),  10, 50, 1'b0);           // zero acts as one
        run_phase(cde_pkg::CAP_W'(2),  20, 55, 1'b0);
        run_phase(cde_pkg::CAP_W'(5),  25, 60, 1'b0);
        run_phase(cde_pkg::CAP_W'($urandom_range(3, 15)), 25, 55, 1'b0);

        wait_drained();
        repeat (20) @(posedge clk);
        if (sb.fail_count == 0 && sb.pending() == 0)
            $display("circular_deque_engine_unit regression: pass");
        else
            $display("circular_deque_engine_unit regression: fail");
        $finish;
    end

endmodule

[circular_deque_engine_unit.f]
hw/rtl/cde_pkg.sv
hw/rtl/circular_deque_engine_unit.sv
tb/testbench.sv
